// ----- rtl/bspa_pkg.sv -----
// Shared types and constants for the bidirectional scan pixel averager.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bspa_pkg;

  localparam int MAX_SAMPLES = 16;
  localparam int MAX_PIXELS  = 1024;
  localparam int MAX_LINES   = 1024;

  localparam int SAMPLE_W = 16;
  localparam int SPP_W    = $clog2(MAX_SAMPLES) + 1;
  localparam int IDX_W    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int PPL_W    = $clog2(MAX_PIXELS) + 1;
  localparam int LPF_W    = $clog2(MAX_LINES) + 1;
  localparam int COL_W    = PPL_W - 1;
  localparam int ROW_W    = LPF_W - 1;
  localparam int SUM_W    = 20;
  localparam int CNT_W    = SPP_W;
  localparam int STEP_W   = $clog2(SUM_W);
  localparam int PIX_W    = 16;

  localparam logic [SAMPLE_W-1:0] SAMPLE_OFFSET = 16'd8192;
  localparam logic [PIX_W-1:0]    PIXEL_MAX     = 16'd57343;

  // configuration register indexes
  localparam int CFG_AW    = 2;
  localparam int CFG_DW    = 11;
  localparam logic [CFG_AW-1:0] CFG_SPP  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_PPL  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_LPF  = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_FLIP = 2'd3;

  // job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             last;
  } pixel_job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

// ----- rtl/bidirectional_scan_pixel_averager_core.sv -----
// Top level of the bidirectional scan pixel averager.
// Depends on bspa_pkg, bspa_front, bspa_queue and bspa_back.
//
// Channel | Direction | Payload
// in_     | slave     | tdata[15:0] raw_sample; tuser frame_start
// out_    | master    | tdata[15:0] value, [25:16] column, [35:26] row; tlast; tuser
// cfg_    | write     | addr 0 spp, 1 pixels/line, 2 lines/frame, 3 flip select
//
// A sample is taken every cycle while the job queue has room. Each pixel
// is loaded by the back end from the queue, divided by the bit-serial
// divider (skipped when nothing was kept) and held in the output register;
// the next pixel is popped only after the output register has been taken.
// Reset is synchronous, active low; it restores register defaults and
// clears the counters and the queue. A stalled output holds the divider,
// and a full four-entry queue holds the input.
`timescale 1ns / 1ps

module bidirectional_scan_pixel_averager_core
  import bspa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // [15:0] raw_sample
  input  logic              in_tuser,   // [0] frame_start
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [39:0]       out_tdata,  // [15:0] pixel_value, [25:16] pixel_column,
                                        // [35:26] pixel_row, [39:36] zero
  output logic              out_tlast,  // frame_last
  output logic              out_tuser   // [0] no_valid_samples
);

  queue_status_t    q_status;
  pixel_job_t       push_job, pop_job;
  logic             push, pop;
  logic [PIX_W-1:0] pix_value;
  logic [COL_W-1:0] pix_column;
  logic [ROW_W-1:0] pix_row;

  bspa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_sample (in_tdata),
    .in_start  (in_tuser),
    .q_status  (q_status),
    .push      (push),
    .push_job  (push_job)
  );

  bspa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .status   (q_status)
  );

  bspa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .pop_job    (pop_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_value  (pix_value),
    .out_column (pix_column),
    .out_row    (pix_row),
    .out_last   (out_tlast),
    .out_none   (out_tuser)
  );

  assign out_tdata = {4'b0000, pix_row, pix_column, pix_value};

  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> pix_value == '0)
    else $error("pixel without kept samples carries a nonzero value");

  a_mean_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pix_value <= PIXEL_MAX)
    else $error("pixel mean above the largest offset-removed sample");

  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({q_status.empty, q_status.full}))
    else $error("job queue reports empty and full at once");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full)
    else $error("pixel job pushed into a full queue");

endmodule

// ----- rtl/bspa_front.sv -----
// Front end: configuration registers, sample accumulation and pixel positioning.
// Depends on bspa_pkg; pushes one pixel job per completed pixel into the queue.
`timescale 1ns / 1ps

module bspa_front
  import bspa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [CFG_DW-1:0]   cfg_wdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                in_start,
  input  queue_status_t       q_status,
  output logic                push,
  output pixel_job_t          push_job
);

  logic [SPP_W-1:0] spp_r;
  logic [PPL_W-1:0] ppl_r;
  logic [LPF_W-1:0] lpf_r;
  logic             flip_r;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [IDX_W-1:0]    base_idx;
  logic [COL_W-1:0]    base_col, col, ppl_m1, col_out;
  logic [ROW_W-1:0]    base_row, row, lpf_m1;
  logic [SUM_W-1:0]    base_sum, sum_acc;
  logic [CNT_W-1:0]    base_cnt, cnt_acc;
  logic                keep, done, accept, col_wrap;
  logic [SAMPLE_W-1:0] diff;

  function automatic logic [SPP_W-1:0] clamp_spp(input logic [CFG_DW-1:0] v);
    logic [SPP_W-1:0] s;
    s = v[SPP_W-1:0];
    if (s == '0) return SPP_W'(1);
    if (s > SPP_W'(MAX_SAMPLES)) return SPP_W'(MAX_SAMPLES);
    return s;
  endfunction

  function automatic logic [PPL_W-1:0] clamp_ppl(input logic [CFG_DW-1:0] v);
    logic [PPL_W-1:0] s;
    s = v[PPL_W-1:0];
    if (s == '0) return PPL_W'(1);
    if (s > PPL_W'(MAX_PIXELS)) return PPL_W'(MAX_PIXELS);
    return s;
  endfunction

  function automatic logic [LPF_W-1:0] clamp_lpf(input logic [CFG_DW-1:0] v);
    logic [LPF_W-1:0] s;
    s = v[LPF_W-1:0];
    if (s == '0) return LPF_W'(1);
    if (s > LPF_W'(MAX_LINES)) return LPF_W'(MAX_LINES);
    return s;
  endfunction

  // store clamped values so downstream logic never sees an out-of-range limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spp_r  <= SPP_W'(1);
      ppl_r  <= PPL_W'(512);
      lpf_r  <= LPF_W'(512);
      flip_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SPP:  spp_r  <= clamp_spp(cfg_wdata);
        CFG_PPL:  ppl_r  <= clamp_ppl(cfg_wdata);
        CFG_LPF:  lpf_r  <= clamp_lpf(cfg_wdata);
        CFG_FLIP: flip_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_tready = !q_status.full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    // frame start clears position and accumulator before this sample counts
    base_idx = in_start ? '0 : idx_r;
    base_col = in_start ? '0 : col_r;
    base_row = in_start ? '0 : row_r;
    base_sum = in_start ? '0 : sum_r;
    base_cnt = in_start ? '0 : cnt_r;

    keep    = in_sample >= SAMPLE_OFFSET;
    diff    = in_sample - SAMPLE_OFFSET;
    sum_acc = base_sum + (keep ? SUM_W'(diff) : '0);
    cnt_acc = base_cnt + CNT_W'(keep);
    done    = (SPP_W'(base_idx) + SPP_W'(1)) >= spp_r;

    ppl_m1 = COL_W'(ppl_r - PPL_W'(1));
    lpf_m1 = ROW_W'(lpf_r - LPF_W'(1));
    // a counter past a shrunk limit counts as the last position
    col = ({1'b0, base_col} < ppl_r) ? base_col : ppl_m1;
    row = ({1'b0, base_row} < lpf_r) ? base_row : lpf_m1;

    col_out  = (row[0] == flip_r) ? (ppl_m1 - col) : col;
    col_wrap = col == ppl_m1;

    push_job.sum    = sum_acc;
    push_job.count  = cnt_acc;
    push_job.column = col_out;
    push_job.row    = row;
    push_job.last   = col_wrap && (row == lpf_m1);
    push            = accept && done;

    idx_nxt = idx_r;
    col_nxt = col_r;
    row_nxt = row_r;
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      if (done) begin
        idx_nxt = '0;
        sum_nxt = '0;
        cnt_nxt = '0;
        col_nxt = col_wrap ? '0 : col + COL_W'(1);
        if (col_wrap) begin
          row_nxt = (row == lpf_m1) ? '0 : row + ROW_W'(1);
        end else begin
          row_nxt = row;
        end
      end else begin
        idx_nxt = base_idx + IDX_W'(1);
        sum_nxt = sum_acc;
        cnt_nxt = cnt_acc;
        col_nxt = base_col;
        row_nxt = base_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      col_r <= '0;
      row_r <= '0;
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      idx_r <= idx_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/bspa_queue.sv -----
// Small FIFO of pixel jobs between the front end and the divider back end.
// Depends on bspa_pkg for the job type and depth.
`timescale 1ns / 1ps

module bspa_queue
  import bspa_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pixel_job_t    push_job,
  input  logic          pop,
  output pixel_job_t    pop_job,
  output queue_status_t status
);

  pixel_job_t       mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     count_r, count_nxt;
  logic             do_push, do_pop;

  assign status.empty = count_r == '0;
  assign status.full  = count_r == (QAW+1)'(QDEPTH);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_job      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    count_nxt  = count_r + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/bspa_back.sv -----
// Back end: bit-serial divider for the pixel mean and the output register.
// Depends on bspa_pkg; pops jobs from bspa_queue.
`timescale 1ns / 1ps

module bspa_back
  import bspa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  queue_status_t    q_status,
  input  pixel_job_t       pop_job,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [PIX_W-1:0] out_value,
  output logic [COL_W-1:0] out_column,
  output logic [ROW_W-1:0] out_row,
  output logic             out_last,
  output logic             out_none
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_HOLD = 3'b100
  } back_state_t;

  back_state_t       state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]  dvd_r, dvd_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  div_r, div_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              last_r, last_nxt;
  logic              none_r, none_nxt;

  logic [CNT_W:0]    trial;
  logic              ge;

  assign pop        = (state_r == ST_IDLE) && !q_status.empty;
  assign out_tvalid = state_r == ST_HOLD;
  assign out_value  = dvd_r[PIX_W-1:0];
  assign out_column = col_r;
  assign out_row    = row_r;
  assign out_last   = last_r;
  assign out_none   = none_r;

  always_comb begin
    // one restoring step: remainder stays below the divisor
    trial = {rem_r, dvd_r[SUM_W-1]};
    ge    = trial >= {1'b0, div_r};

    state_nxt = state_r;
    step_nxt  = step_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    last_nxt  = last_r;
    none_nxt  = none_r;

    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          col_nxt  = pop_job.column;
          row_nxt  = pop_job.row;
          last_nxt = pop_job.last;
          div_nxt  = pop_job.count;
          rem_nxt  = '0;
          step_nxt = '0;
          if (pop_job.count == '0) begin
            dvd_nxt   = '0;
            none_nxt  = 1'b1;
            state_nxt = ST_HOLD;
          end else begin
            dvd_nxt   = pop_job.sum;
            none_nxt  = 1'b0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_nxt  = CNT_W'(ge ? trial - {1'b0, div_r} : trial);
        dvd_nxt  = {dvd_r[SUM_W-2:0], ge};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SUM_W - 1)) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    col_r  <= col_nxt;
    row_r  <= row_nxt;
    last_r <= last_nxt;
    none_r <= none_nxt;
  end

endmodule
